### hdl/one_wire_bus_master_defines.svh
// Assertion macros for the one-wire bus master checker.
`ifndef ONE_WIRE_BUS_MASTER_DEFINES_SVH
`define ONE_WIRE_BUS_MASTER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define OWBM_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define OWBM_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/owbm_pkg.sv
// Types, codes and constants shared by the one-wire bus master modules.
`timescale 1ns / 1ps
`default_nettype none

package owbm_pkg;

  localparam logic [1:0] OP_NONE  = 2'd0;
  localparam logic [1:0] OP_RESET = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  localparam logic [3:0] PH_IDLE  = 4'd0;
  localparam logic [3:0] PH_PRE   = 4'd1;
  localparam logic [3:0] PH_RLOWP = 4'd2;
  localparam logic [3:0] PH_RREL  = 4'd3;
  localparam logic [3:0] PH_PWAIT = 4'd4;
  localparam logic [3:0] PH_PLOW  = 4'd5;
  localparam logic [3:0] PH_WLOW  = 4'd6;
  localparam logic [3:0] PH_WHIGH = 4'd7;
  localparam logic [3:0] PH_SLOW  = 4'd8;
  localparam logic [3:0] PH_SREL  = 4'd9;
  localparam logic [3:0] PH_STAIL = 4'd10;

  localparam logic [2:0] CFG_PRE_REL   = 3'd0;
  localparam logic [2:0] CFG_RST_LOW   = 3'd1;
  localparam logic [2:0] CFG_RST_REL   = 3'd2;
  localparam logic [2:0] CFG_PRES_WAIT = 3'd3;
  localparam logic [2:0] CFG_PRES_LOW  = 3'd4;
  localparam logic [2:0] CFG_SHORT_LOW = 3'd5;
  localparam logic [2:0] CFG_RD_SAMPLE = 3'd6;
  localparam logic [2:0] CFG_WR_SLOT   = 3'd7;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 10;
  localparam logic [3:0]  BIT_LAST   = 4'd8;

  typedef struct packed {
    logic [9:0] pre_rel;
    logic [9:0] rst_low;
    logic [9:0] rst_rel;
    logic [9:0] pres_wait;
    logic [9:0] pres_low;
    logic [5:0] short_low;
    logic [5:0] rd_sample;
    logic [7:0] wr_slot;
  } owbm_cfg_t;

  localparam owbm_cfg_t CFG_RESET = '{
    pre_rel:   10'd50,
    rst_low:   10'd500,
    rst_rel:   10'd40,
    pres_wait: 10'd200,
    pres_low:  10'd240,
    short_low: 6'd2,
    rd_sample: 6'd12,
    wr_slot:   8'd60
  };

  typedef struct packed {
    logic [3:0] phase;
    logic [9:0] timer;
    logic [3:0] bcnt;
    logic [7:0] sbyte;
    logic       absent;
    logic [7:0] last_read;
  } owbm_state_t;

  typedef struct packed {
    logic       absent;
    logic [7:0] read_data;
    logic       done;
    logic       busy;
    logic       drive_low;
  } owbm_res_t;

  function automatic logic [9:0] at_least_one(input logic [9:0] v);
    return (v == 10'd0) ? 10'd1 : v;
  endfunction

endpackage

`default_nettype wire

### hdl/owbm_step.sv
// Next-state and result logic for one microsecond tick of the bus master.
`timescale 1ns / 1ps
`default_nettype none

module owbm_step #(
  parameter int unsigned READ_TAIL_US = 50
) (
  input  owbm_pkg::owbm_cfg_t   cfg_i,
  input  owbm_pkg::owbm_state_t state_i,
  input  logic [1:0]            operation_i,
  input  logic [7:0]            write_data_i,
  input  logic                  line_level_i,
  output owbm_pkg::owbm_state_t state_o,
  output owbm_pkg::owbm_res_t   res_o
);
  import owbm_pkg::*;

  localparam logic [10:0] TailLim = 11'(READ_TAIL_US);

  owbm_state_t st;
  logic [10:0] inc;
  logic [9:0]  lim;
  logic        drive;
  logic        busy;
  logic        done;
  logic        nxt;

  always_comb begin
    st    = state_i;
    drive = 1'b0;
    busy  = 1'b0;
    done  = 1'b0;
    nxt   = 1'b0;
    lim   = '0;
    inc   = '0;

    if (st.phase == PH_IDLE) begin
      st.timer = '0;
      st.bcnt  = '0;
      case (operation_i)
        OP_RESET: begin
          st.phase = (cfg_i.pre_rel == 10'd0) ? PH_RLOWP : PH_PRE;
        end
        OP_WRITE: begin
          st.sbyte = write_data_i;
          st.phase = PH_WLOW;
        end
        OP_READ: begin
          st.sbyte = '0;
          st.phase = PH_SLOW;
        end
        default: ;
      endcase
    end

    if (st.phase != PH_IDLE) begin
      busy  = 1'b1;
      drive = (st.phase == PH_RLOWP) || (st.phase == PH_WLOW) || (st.phase == PH_SLOW);
      inc   = {1'b0, st.timer} + 11'd1;
      unique case (st.phase)
        PH_PRE: begin
          st.timer = inc[9:0];
          if (inc >= {1'b0, cfg_i.pre_rel}) begin
            st.phase = PH_RLOWP;
            nxt      = 1'b1;
          end
        end
        PH_RLOWP: begin
          st.timer = inc[9:0];
          if (inc >= {1'b0, at_least_one(cfg_i.rst_low)}) begin
            st.phase = (cfg_i.rst_rel == 10'd0) ? PH_PWAIT : PH_RREL;
            nxt      = 1'b1;
          end
        end
        PH_RREL: begin
          st.timer = inc[9:0];
          if (inc >= {1'b0, cfg_i.rst_rel}) begin
            st.phase = PH_PWAIT;
            nxt      = 1'b1;
          end
        end
        PH_PWAIT: begin
          if (st.timer >= cfg_i.pres_wait) begin
            st.absent = 1'b1;
            done      = 1'b1;
          end else if (line_level_i) begin
            st.timer = inc[9:0];
            if (inc >= {1'b0, cfg_i.pres_wait}) begin
              st.absent = 1'b1;
              done      = 1'b1;
            end
          end else begin
            st.phase = PH_PLOW;
            st.timer = 10'd1;
            if (cfg_i.pres_low <= 10'd1) begin
              st.absent = 1'b1;
              done      = 1'b1;
            end
          end
        end
        PH_PLOW: begin
          if (st.timer >= cfg_i.pres_low) begin
            st.absent = 1'b1;
            done      = 1'b1;
          end else if (line_level_i) begin
            st.absent = 1'b0;
            done      = 1'b1;
          end else begin
            st.timer = inc[9:0];
            if (inc >= {1'b0, cfg_i.pres_low}) begin
              st.absent = 1'b1;
              done      = 1'b1;
            end
          end
        end
        PH_WLOW: begin
          lim      = at_least_one(st.sbyte[0] ? 10'(cfg_i.short_low) : 10'(cfg_i.wr_slot));
          st.timer = inc[9:0];
          if (inc >= {1'b0, lim}) begin
            st.phase = PH_WHIGH;
            nxt      = 1'b1;
          end
        end
        PH_WHIGH: begin
          lim      = at_least_one(st.sbyte[0] ? 10'(cfg_i.wr_slot) : 10'(cfg_i.short_low));
          st.timer = inc[9:0];
          if (inc >= {1'b0, lim}) begin
            st.sbyte = {1'b0, st.sbyte[7:1]};
            st.bcnt  = st.bcnt + 4'd1;
            if (st.bcnt >= BIT_LAST) begin
              done = 1'b1;
            end else begin
              st.phase = PH_WLOW;
              nxt      = 1'b1;
            end
          end
        end
        PH_SLOW: begin
          st.timer = inc[9:0];
          if (inc >= {1'b0, at_least_one(10'(cfg_i.short_low))}) begin
            st.phase = PH_SREL;
            nxt      = 1'b1;
          end
        end
        PH_SREL: begin
          st.timer = inc[9:0];
          if (inc >= {1'b0, at_least_one(10'(cfg_i.rd_sample))}) begin
            st.phase = PH_STAIL;
            nxt      = 1'b1;
          end
        end
        PH_STAIL: begin
          if (st.timer == 10'd0) begin
            st.sbyte = {line_level_i, st.sbyte[7:1]};
          end
          st.timer = inc[9:0];
          if (inc >= TailLim) begin
            st.bcnt = st.bcnt + 4'd1;
            if (st.bcnt >= BIT_LAST) begin
              st.last_read = st.sbyte;
              done         = 1'b1;
            end else begin
              st.phase = PH_SLOW;
              nxt      = 1'b1;
            end
          end
        end
        default: begin
          done = 1'b1;
        end
      endcase
      if (nxt) begin
        st.timer = '0;
      end
      if (done) begin
        st.phase = PH_IDLE;
        st.timer = '0;
      end
    end
  end

  assign state_o = st;
  assign res_o   = '{
    absent:    st.absent,
    read_data: st.last_read,
    done:      done,
    busy:      busy,
    drive_low: drive
  };

endmodule

`default_nettype wire

### hdl/one_wire_bus_master.sv
// One-wire bus master top level: stream ports, configuration registers, state and result register.
// The result of a tick is registered and appears on the output in the cycle after its input transfer.
// Throughput: one tick per cycle unless the output stalls; a new tick is taken while the output
// holds a result that is being taken in the same cycle.
// Reset: asynchronous, active low; phase idle, counters and flags zero, registers at defaults.
`timescale 1ns / 1ps
`default_nettype none

module one_wire_bus_master #(
  parameter int unsigned READ_TAIL_US = 50
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,  // write_data[7:0], line_level[8], zero pad
  input  logic [1:0]  s_axis_tuser_i,  // operation[1:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,  // drive_low[0], busy_res[1], done_res[2],
                                       // read_data[10:3], device_absent[11], zero pad
  input  logic        cfg_we_i,
  input  logic [owbm_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [owbm_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import owbm_pkg::*;

  owbm_cfg_t   cfg_q;
  owbm_state_t state_q;
  owbm_state_t state_d;
  owbm_res_t   res_d;
  logic        m_valid_q;
  logic [15:0] m_data_q;
  logic        in_xfer;

  assign s_axis_tready_o = !m_valid_q || m_axis_tready_i;
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;

  owbm_step #(
    .READ_TAIL_US(READ_TAIL_US)
  ) u_step (
    .cfg_i       (cfg_q),
    .state_i     (state_q),
    .operation_i (s_axis_tuser_i),
    .write_data_i(s_axis_tdata_i[7:0]),
    .line_level_i(s_axis_tdata_i[8]),
    .state_o     (state_d),
    .res_o       (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PRE_REL:   cfg_q.pre_rel   <= cfg_data_i;
        CFG_RST_LOW:   cfg_q.rst_low   <= cfg_data_i;
        CFG_RST_REL:   cfg_q.rst_rel   <= cfg_data_i;
        CFG_PRES_WAIT: cfg_q.pres_wait <= cfg_data_i;
        CFG_PRES_LOW:  cfg_q.pres_low  <= cfg_data_i;
        CFG_SHORT_LOW: cfg_q.short_low <= cfg_data_i[5:0];
        CFG_RD_SAMPLE: cfg_q.rd_sample <= cfg_data_i[5:0];
        CFG_WR_SLOT:   cfg_q.wr_slot   <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      if (in_xfer) begin
        state_q   <= state_d;
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      m_data_q <= {4'b0000, res_d};
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

endmodule

`default_nettype wire

### hdl/owbm_checker.sv
// Port-level checker for the one-wire bus master, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "one_wire_bus_master_defines.svh"

module owbm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [15:0] m_axis_tdata_o
);

  `OWBM_ASSERT_NEXT(a_in_gives_out, clk_i, rst_ni, s_axis_tvalid_i && s_axis_tready_o, m_axis_tvalid_o, "transfer in did not produce a result")
  `OWBM_ASSERT_NOW(a_ready_when_empty, clk_i, rst_ni, !m_axis_tvalid_o, s_axis_tready_o, "not ready with empty output")
  `OWBM_ASSERT_NOW(a_idle_quiet, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tdata_o[1], !m_axis_tdata_o[0] && !m_axis_tdata_o[2], "bus driven or done while idle")
  `OWBM_ASSERT_NEXT(a_stall_hold, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o), "stalled result changed")

endmodule

bind one_wire_bus_master owbm_checker u_owbm_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .s_axis_tvalid_i(s_axis_tvalid_i),
  .s_axis_tready_o(s_axis_tready_o),
  .m_axis_tvalid_o(m_axis_tvalid_o),
  .m_axis_tready_i(m_axis_tready_i),
  .m_axis_tdata_o (m_axis_tdata_o)
);

`default_nettype wire

### bench/testbench.sv
// Self-checking bench for the one-wire bus master: tick stream in, per-tick bus result out.
`timescale 1ns / 1ps

module testbench;
  import owbm_pkg::*;

  localparam int unsigned TAIL_TICKS  = 50;
  localparam int unsigned STALL_LIMIT = 2000;

  typedef struct {
    logic [1:0] op;
    logic [7:0] wdat;
    logic       lvl;
  } tick_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [15:0] s_axis_tdata_i = '0;  // write_data[7:0], line_level[8], zero pad
  logic [1:0]  s_axis_tuser_i = '0;  // operation[1:0]
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [15:0] m_axis_tdata_o;       // drive_low[0], busy_res[1], done_res[2],
                                     // read_data[10:3], device_absent[11], zero pad
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  tick_t      tick_q[$];
  owbm_res_t  owed_q[$];
  tick_t      nt;
  owbm_res_t  want;
  int         src_idle_pct = 14;
  int         snk_idle_pct = 85;
  int         errors = 0;
  int         stall_cnt = 0;
  int         cmd_ticks = 0;

  // bus model state
  owbm_cfg_t  cfg = CFG_RESET;
  logic [3:0] ph = PH_IDLE;
  logic [9:0] tmr = '0;
  logic [3:0] bcnt = '0;
  logic [7:0] sbyte = '0;
  logic       absent = 1'b0;
  logic [7:0] last_rd = '0;

  always #2 clk_i = ~clk_i;

  one_wire_bus_master #(.READ_TAIL_US(TAIL_TICKS)) u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i)
  );

  function automatic int unsigned floor1(input int unsigned v);
    return (v == 0) ? 1 : v;
  endfunction

  function automatic logic [3:0] reset_entry(input logic [3:0] p);
    logic [3:0] q;
    q = p;
    if (q == PH_PRE && cfg.pre_rel == 0) q = PH_RLOWP;
    if (q == PH_RREL && cfg.rst_rel == 0) q = PH_PWAIT;
    return q;
  endfunction

  function automatic owbm_res_t bus_tick(input logic [1:0] op, input logic [7:0] wd,
                                         input logic lvl);
    owbm_res_t   r;
    int unsigned t;
    logic        fin;
    logic        nxt;
    logic        lsb;
    r = '0;
    fin = 1'b0;
    nxt = 1'b0;
    if (ph == PH_IDLE) begin
      tmr = '0;
      bcnt = '0;
      case (op)
        OP_RESET: ph = reset_entry(PH_PRE);
        OP_WRITE: begin
          sbyte = wd;
          ph = PH_WLOW;
        end
        OP_READ: begin
          sbyte = '0;
          ph = PH_SLOW;
        end
        default: ;
      endcase
    end
    if (ph != PH_IDLE) begin
      r.busy = 1'b1;
      lsb = sbyte[0];
      r.drive_low = (ph == PH_RLOWP || ph == PH_WLOW || ph == PH_SLOW);
      t = tmr;
      case (ph)
        PH_PRE: begin
          t++;
          if (t >= cfg.pre_rel) begin
            ph = reset_entry(PH_RLOWP);
            nxt = 1'b1;
          end
        end
        PH_RLOWP: begin
          t++;
          if (t >= floor1(cfg.rst_low)) begin
            ph = reset_entry(PH_RREL);
            nxt = 1'b1;
          end
        end
        PH_RREL: begin
          t++;
          if (t >= cfg.rst_rel) begin
            ph = PH_PWAIT;
            nxt = 1'b1;
          end
        end
        PH_PWAIT: begin
          if (t >= cfg.pres_wait) begin
            absent = 1'b1;
            fin = 1'b1;
          end else if (lvl) begin
            t++;
            if (t >= cfg.pres_wait) begin
              absent = 1'b1;
              fin = 1'b1;
            end
          end else begin
            ph = PH_PLOW;
            t = 1;
            if (t >= cfg.pres_low) begin
              absent = 1'b1;
              fin = 1'b1;
            end
          end
        end
        PH_PLOW: begin
          if (t >= cfg.pres_low) begin
            absent = 1'b1;
            fin = 1'b1;
          end else if (lvl) begin
            absent = 1'b0;
            fin = 1'b1;
          end else begin
            t++;
            if (t >= cfg.pres_low) begin
              absent = 1'b1;
              fin = 1'b1;
            end
          end
        end
        PH_WLOW: begin
          t++;
          if (t >= floor1(lsb ? cfg.short_low : cfg.wr_slot)) begin
            ph = PH_WHIGH;
            nxt = 1'b1;
          end
        end
        PH_WHIGH: begin
          t++;
          if (t >= floor1(lsb ? cfg.wr_slot : cfg.short_low)) begin
            sbyte = sbyte >> 1;
            bcnt++;
            if (bcnt >= BIT_LAST) fin = 1'b1;
            else begin
              ph = PH_WLOW;
              nxt = 1'b1;
            end
          end
        end
        PH_SLOW: begin
          t++;
          if (t >= floor1(cfg.short_low)) begin
            ph = PH_SREL;
            nxt = 1'b1;
          end
        end
        PH_SREL: begin
          t++;
          if (t >= floor1(cfg.rd_sample)) begin
            ph = PH_STAIL;
            nxt = 1'b1;
          end
        end
        PH_STAIL: begin
          if (t == 0) sbyte = {lvl, sbyte[7:1]};
          t++;
          if (t >= TAIL_TICKS) begin
            bcnt++;
            if (bcnt >= BIT_LAST) begin
              last_rd = sbyte;
              fin = 1'b1;
            end else begin
              ph = PH_SLOW;
              nxt = 1'b1;
            end
          end
        end
        default: fin = 1'b1;
      endcase
      if (nxt) t = 0;
      if (fin) begin
        ph = PH_IDLE;
        t = 0;
      end
      tmr = t[9:0];
    end
    r.done = fin;
    r.read_data = last_rd;
    r.absent = absent;
    return r;
  endfunction

  task automatic check_field(input string name, input int unsigned w, input int unsigned g);
    if (w != g) begin
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, w, g);
      errors++;
    end
  endtask

  // source side: predict on each accepted tick, then present the next one
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o)
        owed_q.push_back(bus_tick(s_axis_tuser_i, s_axis_tdata_i[7:0], s_axis_tdata_i[8]));
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (tick_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          nt = tick_q.pop_front();
          s_axis_tvalid_i <= 1'b1;
          s_axis_tuser_i  <= nt.op;
          s_axis_tdata_i  <= {7'd0, nt.lvl, nt.wdat};
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // result side
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (owed_q.size() == 0) begin
          $display("%0t ns: result with nothing expected, expected none, actual %h",
                   $time, m_axis_tdata_o);
          errors++;
        end else begin
          want = owed_q.pop_front();
          check_field("drive_low", want.drive_low, m_axis_tdata_o[0]);
          check_field("busy_res", want.busy, m_axis_tdata_o[1]);
          check_field("done_res", want.done, m_axis_tdata_o[2]);
          check_field("read_data", want.read_data, m_axis_tdata_o[10:3]);
          check_field("device_absent", want.absent, m_axis_tdata_o[11]);
        end
      end
      m_axis_tready_i <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      stall_cnt <= 0;
    else
      stall_cnt <= stall_cnt + 1;
    if (stall_cnt >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic push_tick(input logic [1:0] op, input logic [7:0] wd, input logic lvl);
    tick_q.push_back('{op, wd, lvl});
  endtask

  // commands issued mid-command must be ignored
  function automatic logic [1:0] busy_op();
    return ($urandom_range(6) == 0) ? 2'($urandom) : OP_NONE;
  endfunction

  task automatic settle();
    forever begin
      while (tick_q.size() != 0 || s_axis_tvalid_i || owed_q.size() != 0) @(negedge clk_i);
      if (ph == PH_IDLE) break;
      repeat (4) push_tick(OP_NONE, 8'($urandom), 1'($urandom));
    end
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    case (idx)
      CFG_PRE_REL:   cfg.pre_rel   = val;
      CFG_RST_LOW:   cfg.rst_low   = val;
      CFG_RST_REL:   cfg.rst_rel   = val;
      CFG_PRES_WAIT: cfg.pres_wait = val;
      CFG_PRES_LOW:  cfg.pres_low  = val;
      CFG_SHORT_LOW: cfg.short_low = val[5:0];
      CFG_RD_SAMPLE: cfg.rd_sample = val[5:0];
      CFG_WR_SLOT:   cfg.wr_slot   = val[7:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic load_cfg(input owbm_cfg_t c);
    set_reg(CFG_PRE_REL, c.pre_rel);
    set_reg(CFG_RST_LOW, c.rst_low);
    set_reg(CFG_RST_REL, c.rst_rel);
    set_reg(CFG_PRES_WAIT, c.pres_wait);
    set_reg(CFG_PRES_LOW, c.pres_low);
    set_reg(CFG_SHORT_LOW, 10'(c.short_low));
    set_reg(CFG_RD_SAMPLE, 10'(c.rd_sample));
    set_reg(CFG_WR_SLOT, 10'(c.wr_slot));
  endtask

  // lv < 0 gives random line levels, else a constant level
  task automatic issue_xfer(input logic [1:0] op, input logic [7:0] wd, input int lv);
    int n;
    int i;
    if (op == OP_WRITE)
      n = 8 * int'(floor1(cfg.short_low) + floor1(cfg.wr_slot));
    else
      n = 8 * int'(floor1(cfg.short_low) + floor1(cfg.rd_sample) + TAIL_TICKS);
    for (i = 0; i < n; i++)
      push_tick((i == 0) ? op : busy_op(), (i == 0) ? wd : 8'($urandom),
                (lv < 0) ? 1'($urandom) : lv[0]);
    cmd_ticks += n;
  endtask

  // tidy: h high ticks, l low ticks, then high; otherwise h ticks of random level
  task automatic issue_reset(input int h, input int l, input bit tidy);
    int n;
    int i;
    n = int'(cfg.pre_rel) + int'(floor1(cfg.rst_low)) + int'(cfg.rst_rel);
    for (i = 0; i < n; i++)
      push_tick((i == 0) ? OP_RESET : busy_op(), 8'($urandom), 1'($urandom));
    if (tidy) begin
      repeat (h) push_tick(OP_NONE, 8'($urandom), 1'b1);
      repeat (l) push_tick(OP_NONE, 8'($urandom), 1'b0);
      push_tick(OP_NONE, 8'($urandom), 1'b1);
    end else begin
      repeat (h) push_tick(OP_NONE, 8'($urandom), 1'($urandom));
    end
    cmd_ticks += n + h + l;
  endtask

  initial begin : stim
    owbm_cfg_t rc;
    int        k;
    int        pick;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // defaults, device answers
    src_idle_pct = 14;
    snk_idle_pct = 85;
    issue_reset(2, 4, 1'b1);
    settle();

    // zero durations and zero presence wait
    src_idle_pct = 85;
    snk_idle_pct = 14;
    rc = '{pre_rel: 0, rst_low: 0, rst_rel: 0, pres_wait: 0, pres_low: 5,
           short_low: 0, rd_sample: 0, wr_slot: 0};
    load_cfg(rc);
    issue_reset(0, 1, 1'b1);
    issue_xfer(OP_WRITE, 8'h00, -1);
    issue_xfer(OP_WRITE, 8'hFF, -1);
    issue_xfer(OP_WRITE, 8'h5A, -1);
    issue_xfer(OP_READ, 8'hFF, -1);
    settle();

    // zero presence low limit, then wait limit reached
    src_idle_pct = 0;
    snk_idle_pct = 0;
    rc = '{pre_rel: 1, rst_low: 1, rst_rel: 1, pres_wait: 3, pres_low: 0,
           short_low: 1, rd_sample: 1, wr_slot: 1};
    load_cfg(rc);
    issue_reset(1, 1, 1'b1);
    issue_reset(3, 1, 1'b1);
    settle();

    rc = '{pre_rel: 2, rst_low: 3, rst_rel: 2, pres_wait: 4, pres_low: 3,
           short_low: 3, rd_sample: 2, wr_slot: 5};
    load_cfg(rc);
    issue_reset(0, 2, 1'b1);
    issue_reset(2, 3, 1'b1);
    issue_reset(4, 1, 1'b1);
    issue_xfer(OP_WRITE, 8'h96, -1);
    settle();

    // narrow registers masked to their width
    set_reg(CFG_SHORT_LOW, 10'h3C1);
    set_reg(CFG_RD_SAMPLE, 10'h3C2);
    set_reg(CFG_WR_SLOT, 10'h302);
    issue_reset(1, 1, 1'b1);
    issue_xfer(OP_WRITE, 8'hC3, -1);

    for (k = 0; k < 2; k++) begin
      settle();
      rc.pre_rel   = 10'($urandom_range(0, 4));
      rc.rst_low   = 10'($urandom_range(0, 6));
      rc.rst_rel   = 10'($urandom_range(0, 4));
      rc.pres_wait = 10'($urandom_range(0, 8));
      rc.pres_low  = 10'($urandom_range(0, 8));
      rc.short_low = 6'($urandom_range(0, 4));
      rc.rd_sample = 6'($urandom_range(0, 4));
      rc.wr_slot   = 8'($urandom_range(0, 8));
      load_cfg(rc);
      cmd_ticks = 0;
      while (cmd_ticks < 30) begin
        pick = $urandom_range(0, 9);
        if (pick < 5) begin
          if ($urandom_range(0, 4) == 0) begin
            issue_reset($urandom_range(1, 2 * (cfg.pres_wait + cfg.pres_low) + 2), 0, 1'b0);
            settle();
          end else begin
            issue_reset($urandom_range(0, cfg.pres_wait), $urandom_range(1, cfg.pres_low + 1),
                        1'b1);
          end
        end else begin
          issue_xfer(OP_WRITE, 8'($urandom), -1);
        end
        if ($urandom_range(0, 4) == 0)
          repeat ($urandom_range(1, 3)) push_tick(OP_NONE, 8'($urandom), 1'($urandom));
      end
    end

    settle();
    repeat (8) @(posedge clk_i);
    if (errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
